/* design/tsmrg_pkg.sv */
package tsmrg_pkg;

    // Operation codes carried in the input tuser field.
    localparam logic [1:0] OP_PUSH      = 2'd0;
    localparam logic [1:0] OP_DRAIN_ALL = 2'd1;
    localparam logic [1:0] OP_DRAIN_OLD = 2'd2;

    // Result status codes carried in the output tuser field.
    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_LATE_DROP = 3'd1;
    localparam logic [2:0] ST_FULL_DROP = 3'd2;
    localparam logic [2:0] ST_ORDER_DROP = 3'd3;
    localparam logic [2:0] ST_EMITTED   = 3'd4;
    localparam logic [2:0] ST_NOTHING   = 3'd5;

    // Most events released by one drain request.
    localparam int         MAX_EMIT     = 64;
    localparam int         EMIT_W       = 7;

    localparam int         TS_W         = 64;
    localparam int         PL_W         = 32;
    localparam int         CNT_W        = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_DECIDE,
        S_REFILL,
        S_FINAL,
        S_NONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic push;
        logic scan_clr;
        logic scan_step;
        logic pop;
        logic refill;
        logic out_pend;
        logic out_last;
        logic out_nothing;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] in_op;
        logic       out_busy;
        logic       scan_last;
        logic       eligible;
        logic       pend_valid;
        logic       emit_cap;
    } t_dp_status;

endpackage

/* design/tsmrg_ctrl.sv */
module tsmrg_ctrl
    import tsmrg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    priority if (i_status.in_op == OP_PUSH) begin
                        n_state = S_PUSH;
                    end else if (i_status.in_op == OP_DRAIN_ALL ||
                                 i_status.in_op == OP_DRAIN_OLD) begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end else begin
                        n_state = S_NONE;
                    end
                end
            end
            S_PUSH: begin
                if (!i_status.out_busy) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_status.out_busy) begin
                    if (i_status.eligible) begin
                        // Release the previous event and take the new minimum.
                        o_cmd.pop      = 1'b1;
                        o_cmd.out_pend = i_status.pend_valid;
                        n_state        = S_REFILL;
                    end else if (i_status.pend_valid) begin
                        o_cmd.out_pend = 1'b1;
                        o_cmd.out_last = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.out_nothing = 1'b1;
                        n_state           = S_IDLE;
                    end
                end
            end
            S_REFILL: begin
                o_cmd.refill = 1'b1;
                if (i_status.emit_cap) begin
                    n_state = S_FINAL;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_FINAL: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_pend = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_NONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_nothing = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/tsmrg_dp.sv */
module tsmrg_dp
    import tsmrg_pkg::*;
#(
    parameter int NUM_SOURCES = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic [1:0]        i_op,
    input  logic [1:0]        i_src,
    input  logic [TS_W-1:0]   i_ts,
    input  logic [PL_W-1:0]   i_pl,
    input  logic [TS_W-1:0]   i_now,
    input  logic [31:0]       i_hold,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [2:0]        o_out_status,
    output logic [1:0]        o_out_src,
    output logic [TS_W-1:0]   o_out_ts,
    output logic [PL_W-1:0]   o_out_pl,
    output logic [CNT_W-1:0]  o_out_discard,
    output logic              o_out_last
);

    localparam int SW  = $clog2(NUM_SOURCES);
    localparam int HW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int DEP = NUM_SOURCES * QUEUE_DEPTH;
    localparam int AW  = $clog2(DEP);

    // Event store and per-source queue state.
    logic [TS_W+PL_W-1:0] r_mem [DEP];
    logic [TS_W+PL_W-1:0] r_rdata;
    logic [HW-1:0]        r_head [NUM_SOURCES];
    logic [CW-1:0]        r_count [NUM_SOURCES];
    logic [TS_W-1:0]      r_newest [NUM_SOURCES];
    logic [TS_W-1:0]      r_hts [NUM_SOURCES];
    logic [PL_W-1:0]      r_hpl [NUM_SOURCES];
    logic [TS_W-1:0]      r_last_emit;
    logic [CNT_W-1:0]     r_discard;

    // Captured request.
    logic [1:0]           r_op;
    logic [1:0]           r_src;
    logic [TS_W-1:0]      r_ts;
    logic [PL_W-1:0]      r_pl;
    logic [TS_W-1:0]      r_now;

    // Scan and pending event.
    logic [SW-1:0]        r_ptr;
    logic                 r_found;
    logic [SW-1:0]        r_best_src;
    logic [TS_W-1:0]      r_best_ts;
    logic [PL_W-1:0]      r_best_pl;
    logic [HW-1:0]        r_best_head;
    logic [CW-1:0]        r_best_cnt;
    logic                 r_refill_en;
    logic                 r_pend_valid;
    logic [SW-1:0]        r_pend_src;
    logic [TS_W-1:0]      r_pend_ts;
    logic [PL_W-1:0]      r_pend_pl;
    logic [EMIT_W-1:0]    r_emit_n;

    // Output register.
    logic                 r_ov;
    logic [2:0]           r_ost;
    logic [1:0]           r_osrc;
    logic [TS_W-1:0]      r_ots;
    logic [PL_W-1:0]      r_opl;
    logic [CNT_W-1:0]     r_odisc;
    logic                 r_olast;

    logic [CW-1:0]        cur_cnt;
    logic [HW-1:0]        cur_head;
    logic                 in_range;
    logic [2:0]           push_st;
    logic [CW:0]          pos_sum;
    logic [HW-1:0]        pos;
    logic [AW-1:0]        wr_addr;
    logic [HW-1:0]        next_head;
    logic [AW-1:0]        rd_addr;
    logic [TS_W:0]        aged_sum;
    logic                 is_old;
    logic [CNT_W-1:0]     n_discard;

    assign cur_cnt  = r_count[r_ptr];
    assign cur_head = r_head[r_ptr];
    assign in_range = 32'(r_src) < NUM_SOURCES;

    // Push checks in order of precedence.
    always_comb begin
        priority if (r_last_emit != '0 && r_ts < r_last_emit) begin
            push_st = ST_LATE_DROP;
        end else if (!in_range) begin
            push_st = ST_FULL_DROP;
        end else if (cur_cnt != '0 && r_ts < r_newest[r_ptr]) begin
            push_st = ST_ORDER_DROP;
        end else if (32'(cur_cnt) >= QUEUE_DEPTH) begin
            push_st = ST_FULL_DROP;
        end else begin
            push_st = ST_ACCEPTED;
        end
    end

    // Tail position of the target queue, wrapped once.
    always_comb begin
        pos_sum = (CW+1)'(cur_head) + (CW+1)'(cur_cnt);
        if (32'(pos_sum) >= QUEUE_DEPTH) begin
            pos = HW'(32'(pos_sum) - QUEUE_DEPTH);
        end else begin
            pos = HW'(pos_sum);
        end
        wr_addr = AW'(r_ptr) * AW'(QUEUE_DEPTH) + AW'(pos);
    end

    // Head after a pop and the store address of the next head entry.
    always_comb begin
        if (32'(r_best_head) == QUEUE_DEPTH - 1) begin
            next_head = '0;
        end else begin
            next_head = r_best_head + HW'(1);
        end
        rd_addr = AW'(r_best_src) * AW'(QUEUE_DEPTH) + AW'(next_head);
    end

    // Age test on a 65-bit sum.
    assign aged_sum = {1'b0, r_best_ts} + (TS_W+1)'(i_hold);
    assign is_old   = aged_sum < {1'b0, r_now};

    assign n_discard = (push_st != ST_ACCEPTED && r_discard != '1)
                       ? r_discard + CNT_W'(1) : r_discard;

    // Event store, one write and one registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && push_st == ST_ACCEPTED) begin
            r_mem[wr_addr] <= {r_ts, r_pl};
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Queue control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SOURCES; s++) begin
                r_head[s]   <= '0;
                r_count[s]  <= '0;
                r_newest[s] <= '0;
            end
            r_last_emit  <= '0;
            r_discard    <= '0;
            r_pend_valid <= 1'b0;
            r_emit_n     <= '0;
            r_found      <= 1'b0;
            r_ptr        <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_pend_valid <= 1'b0;
                r_emit_n     <= '0;
            end
            if (i_cmd.push) begin
                r_discard <= n_discard;
                if (push_st == ST_ACCEPTED) begin
                    r_count[r_ptr]  <= cur_cnt + CW'(1);
                    r_newest[r_ptr] <= r_ts;
                end
            end
            // Scan pointer: cleared for a scan, else it selects the pushed source.
            if (i_cmd.scan_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.capture) begin
                r_ptr <= SW'(i_src);
            end else if (i_cmd.scan_step) begin
                r_ptr <= r_ptr + SW'(1);
            end
            if (i_cmd.scan_clr) begin
                r_found <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (cur_cnt != '0 && (!r_found || r_hts[r_ptr] < r_best_ts)) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.pop) begin
                r_head[r_best_src]  <= next_head;
                r_count[r_best_src] <= r_best_cnt - CW'(1);
                r_last_emit         <= r_best_ts;
                r_pend_valid        <= 1'b1;
                r_emit_n            <= r_emit_n + EMIT_W'(1);
            end
        end
    end

    // Captured fields, head cache, best candidate and pending event.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_op;
            r_src <= i_src;
            r_ts  <= i_ts;
            r_pl  <= i_pl;
            r_now <= i_now;
        end
        if (i_cmd.push && push_st == ST_ACCEPTED && cur_cnt == '0) begin
            r_hts[r_ptr] <= r_ts;
            r_hpl[r_ptr] <= r_pl;
        end
        if (i_cmd.scan_step && cur_cnt != '0 &&
            (!r_found || r_hts[r_ptr] < r_best_ts)) begin
            r_best_src  <= r_ptr;
            r_best_ts   <= r_hts[r_ptr];
            r_best_pl   <= r_hpl[r_ptr];
            r_best_head <= cur_head;
            r_best_cnt  <= cur_cnt;
        end
        if (i_cmd.pop) begin
            r_pend_src  <= r_best_src;
            r_pend_ts   <= r_best_ts;
            r_pend_pl   <= r_best_pl;
            r_refill_en <= r_best_cnt > CW'(1);
        end
        if (i_cmd.refill && r_refill_en) begin
            r_hts[r_pend_src] <= r_rdata[TS_W+PL_W-1:PL_W];
            r_hpl[r_pend_src] <= r_rdata[PL_W-1:0];
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.push || i_cmd.out_pend || i_cmd.out_nothing) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_ost   <= push_st;
            r_osrc  <= r_src;
            r_ots   <= '0;
            r_opl   <= '0;
            r_odisc <= n_discard;
            r_olast <= 1'b1;
        end else if (i_cmd.out_pend) begin
            r_ost   <= ST_EMITTED;
            r_osrc  <= 2'(r_pend_src);
            r_ots   <= r_pend_ts;
            r_opl   <= r_pend_pl;
            r_odisc <= r_discard;
            r_olast <= i_cmd.out_last;
        end else if (i_cmd.out_nothing) begin
            r_ost   <= ST_NOTHING;
            r_osrc  <= '0;
            r_ots   <= '0;
            r_opl   <= '0;
            r_odisc <= r_discard;
            r_olast <= 1'b1;
        end
    end

    assign o_status.in_op      = i_op;
    assign o_status.out_busy   = r_ov;
    assign o_status.scan_last  = 32'(r_ptr) == NUM_SOURCES - 1;
    assign o_status.eligible   = r_found && (r_op == OP_DRAIN_ALL || is_old);
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.emit_cap   = 32'(r_emit_n) == MAX_EMIT;

    assign o_out_valid   = r_ov;
    assign o_out_status  = r_ost;
    assign o_out_src     = r_osrc;
    assign o_out_ts      = r_ots;
    assign o_out_pl      = r_opl;
    assign o_out_discard = r_odisc;
    assign o_out_last    = r_olast;

endmodule

/* design/timestamp_ordered_multi_source_merge_core.sv */
// Merges time-ordered event streams from several sources into one stream in
// global timestamp order.
// Input stream: tuser carries the operation (push, drain all, drain old);
// tdata carries source, timestamp, payload and current time. A push answers
// with one result: accepted, or a late, full or source-order drop that bumps
// the saturating discard count. A drain answers with up to 64 emitted events,
// smallest timestamp first and ties to the lowest source, or one "nothing"
// result; tlast marks the final result of each request.
// Sequence: a push is captured, then checked and written to its queue. Each
// drained event passes through a scan of the per-source head registers one
// source a cycle, the age compare and pop, and the store read that refills
// the popped head. A request is taken only once the previous one has placed
// all its results in the output register.
// Output register: a stalled receiver holds the result in place and the
// block waits until the register is free before making the next result.
// Reset clears queue counts, the last emitted time, the discard count and
// the hold delay; the event store needs no clearing.
// The hold delay register lies at APB byte address 0.
module timestamp_ordered_multi_source_merge_core
    import tsmrg_pkg::*;
#(
    parameter int NUM_SOURCES = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: source[1:0], timestamp[65:2], payload[97:66], current_time[161:98]
    input  logic [167:0] s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: out_source[1:0], out_timestamp[65:2], out_payload[97:66],
    // discard_count[129:98]
    output logic [135:0] m_axis_tdata,
    // tuser: status[2:0]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    t_dp_cmd          cmd;
    t_dp_status       status;
    logic [31:0]      r_hold;
    logic [1:0]       out_src;
    logic [TS_W-1:0]  out_ts;
    logic [PL_W-1:0]  out_pl;
    logic [CNT_W-1:0] out_disc;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
        end else if (psel && penable && pwrite && paddr == 3'd0) begin
            r_hold <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? r_hold : 32'd0;

    tsmrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tsmrg_dp #(
        .NUM_SOURCES (NUM_SOURCES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_op          (s_axis_tuser),
        .i_src         (s_axis_tdata[1:0]),
        .i_ts          (s_axis_tdata[65:2]),
        .i_pl          (s_axis_tdata[97:66]),
        .i_now         (s_axis_tdata[161:98]),
        .i_hold        (r_hold),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_status  (m_axis_tuser),
        .o_out_src     (out_src),
        .o_out_ts      (out_ts),
        .o_out_pl      (out_pl),
        .o_out_discard (out_disc),
        .o_out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_disc, out_pl, out_ts, out_src};

`ifndef NO_ASSERTIONS
    // A taken request keeps the input closed in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a request was taken");

    // Every result other than an emitted event is the only result of its request.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_EMITTED |-> m_axis_tlast)
        else $error("non-emit result without tlast");

    // The input is closed while a non-final result waits in the output register.
    a_no_accept_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("request taken during a drain");
`endif

endmodule

/* dv/tb_timestamp_ordered_multi_source_merge_core.sv */
module tb_timestamp_ordered_multi_source_merge_core;
    import tsmrg_pkg::*;

    localparam int NSRC      = 4;
    localparam int QDEPTH    = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam logic [2:0] ADDR_HOLD  = 3'd0;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  src;
        logic [63:0] ts;
        logic [31:0] pl;
        logic [63:0] now;
    } t_request;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  src;
        logic [63:0] ts;
        logic [31:0] pl;
        logic [31:0] discards;
        logic        last;
    } t_result;

    // Directed row: a request and, where obvious, the single result it causes.
    typedef struct {
        t_request req;
        logic     typed;
        t_result  res;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    timestamp_ordered_multi_source_merge_core #(
        .NUM_SOURCES(NSRC),
        .QUEUE_DEPTH(QDEPTH)
    ) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the merge state.
    logic [63:0] q_ts [NSRC][QDEPTH];
    logic [31:0] q_pl [NSRC][QDEPTH];
    int          q_head [NSRC];
    int          q_count [NSRC];
    logic [63:0] q_newest [NSRC];
    logic [63:0] last_emitted;
    logic [31:0] discard_total;
    logic [31:0] hold_delay;

    t_result expected_results [$];
    int      errors = 0;
    int      sent = 0;
    int      received = 0;
    int      emitted = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      idle_cycles = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("MISMATCH result %0d %s: got %0h expected %0h", received, what, got, want);
    endtask

    function automatic void bump_discards();
        if (discard_total != 32'hFFFF_FFFF) discard_total++;
    endfunction

    // Works out the results of one request and updates the shadow state.
    function automatic void merge_predict(input t_request r);
        t_result res;
        int n;
        int best;
        logic [64:0] aged;
        res = '0;
        if (r.op == OP_PUSH) begin
            if (last_emitted != 0 && r.ts < last_emitted) begin
                res.status = ST_LATE_DROP;
            end else if (q_count[r.src] != 0 && r.ts < q_newest[r.src]) begin
                res.status = ST_ORDER_DROP;
            end else if (q_count[r.src] >= QDEPTH) begin
                res.status = ST_FULL_DROP;
            end else begin
                q_ts[r.src][(q_head[r.src] + q_count[r.src]) % QDEPTH] = r.ts;
                q_pl[r.src][(q_head[r.src] + q_count[r.src]) % QDEPTH] = r.pl;
                q_count[r.src]++;
                q_newest[r.src] = r.ts;
                res.status = ST_ACCEPTED;
            end
            if (res.status != ST_ACCEPTED) bump_discards();
            res.src = r.src;
            res.discards = discard_total;
            res.last = 1'b1;
            expected_results.push_back(res);
            return;
        end
        n = 0;
        if (r.op == OP_DRAIN_ALL || r.op == OP_DRAIN_OLD) begin
            while (n < MAX_EMIT) begin
                best = -1;
                for (int s = 0; s < NSRC; s++)
                    if (q_count[s] != 0 &&
                        (best < 0 || q_ts[s][q_head[s]] < q_ts[best][q_head[best]]))
                        best = s;
                if (best < 0) break;
                if (r.op == OP_DRAIN_OLD) begin
                    aged = {1'b0, q_ts[best][q_head[best]]} + {33'd0, hold_delay};
                    if (aged[64] || aged[63:0] >= r.now) break;
                end
                last_emitted = q_ts[best][q_head[best]];
                res.status = ST_EMITTED;
                res.src = best[1:0];
                res.ts = q_ts[best][q_head[best]];
                res.pl = q_pl[best][q_head[best]];
                res.discards = discard_total;
                res.last = 1'b0;
                expected_results.push_back(res);
                q_head[best] = (q_head[best] + 1) % QDEPTH;
                q_count[best]--;
                n++;
            end
        end
        if (n > 0) begin
            expected_results[$].last = 1'b1;
        end else begin
            res = '0;
            res.status = ST_NOTHING;
            res.discards = discard_total;
            res.last = 1'b1;
            expected_results.push_back(res);
        end
    endfunction

    // Sends one request on the input stream, holding it until accepted.
    // Starts and ends at a falling edge; valid stays up for a following request.
    task automatic send_request(input t_request r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.op;
        s_axis_tdata  <= {6'd0, r.now, r.pl, r.ts, r.src};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        merge_predict(r);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic write_hold(input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_HOLD; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        hold_delay = value;
    endtask

    // Closes the input, waits for every expected result, then lets the block settle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    function automatic t_request make_req(input logic [1:0] op, input logic [1:0] src,
                                          input logic [63:0] ts, input logic [31:0] pl,
                                          input logic [63:0] now);
        t_request r;
        r.op = op; r.src = src; r.ts = ts; r.pl = pl; r.now = now;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Receiver: random stalls, result check against the oldest expectation.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tuser;
            got.src = m_axis_tdata[1:0];
            got.ts = m_axis_tdata[65:2];
            got.pl = m_axis_tdata[97:66];
            got.discards = m_axis_tdata[129:98];
            got.last = m_axis_tlast;
            if (expected_results.size() == 0) begin
                errors++;
                $display("UNEXPECTED result: status %0d", got.status);
            end else begin
                want = expected_results.pop_front();
                if (got.status != want.status) report_mismatch("status", got.status, want.status);
                if (got.src != want.src) report_mismatch("source", got.src, want.src);
                if (got.ts != want.ts) report_mismatch("timestamp", got.ts, want.ts);
                if (got.pl != want.pl) report_mismatch("payload", got.pl, want.pl);
                if (got.discards != want.discards)
                    report_mismatch("discard count", got.discards, want.discards);
                if (got.last != want.last) report_mismatch("last", got.last, want.last);
                if (want.status == ST_EMITTED) emitted++;
            end
            received++;
        end
    end

    // Watchdog on cycles in which no request and no result moves.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    t_row rows [$];
    t_request req;
    t_result exp_one;
    int phase_pct [4][2] = '{'{0, 0}, '{50, 0}, '{0, 50}, '{9, 9}};
    logic [31:0] hold_settings [4] = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd1};
    logic [63:0] base;

    initial begin
        for (int s = 0; s < NSRC; s++) begin
            q_head[s] = 0; q_count[s] = 0; q_newest[s] = '0;
        end
        last_emitted = '0; discard_total = '0; hold_delay = '0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table: expected result typed only for the obvious rows.
        exp_one = '0; exp_one.status = ST_NOTHING; exp_one.last = 1'b1;
        rows.push_back('{make_req(OP_DRAIN_ALL, 2'd0, '0, '0, '0), 1'b1, exp_one});
        rows.push_back('{make_req(OP_DRAIN_OLD, 2'd0, '0, '0, '1), 1'b1, exp_one});
        rows.push_back('{make_req(OP_UNKNOWN, 2'd3, '1, '1, '1), 1'b1, exp_one});
        exp_one.status = ST_ACCEPTED; exp_one.src = 2'd0;
        rows.push_back('{make_req(OP_PUSH, 2'd0, '0, '0, '0), 1'b1, exp_one});
        exp_one.src = 2'd3;
        rows.push_back('{make_req(OP_PUSH, 2'd3, '1, '1, '0), 1'b1, exp_one});
        rows.push_back('{make_req(OP_PUSH, 2'd1, 64'd500, 32'hA5A5_5A5A, '0), 1'b0, exp_one});
        rows.push_back('{make_req(OP_PUSH, 2'd1, 64'd400, 32'h1, '0), 1'b0, exp_one});
        rows.push_back('{make_req(OP_PUSH, 2'd2, 64'd500, 32'h2, '0), 1'b0, exp_one});
        rows.push_back('{make_req(OP_DRAIN_OLD, 2'd0, '0, '0, 64'd501), 1'b0, exp_one});
        rows.push_back('{make_req(OP_DRAIN_OLD, 2'd0, '0, '0, '1), 1'b0, exp_one});
        rows.push_back('{make_req(OP_PUSH, 2'd2, 64'd10, 32'h3, '0), 1'b0, exp_one});
        for (int k = 0; k < QDEPTH + 1; k++)
            rows.push_back('{make_req(OP_PUSH, 2'd1, 64'hFFFF_FFFF_FFFF_0000 + 64'(k),
                                      32'(k), '0), 1'b0, exp_one});
        rows.push_back('{make_req(OP_DRAIN_ALL, 2'd0, '0, '0, '0), 1'b0, exp_one});
        foreach (rows[i]) begin
            send_request(rows[i].req);
            if (rows[i].typed) begin
                // The predictor already holds this result; the typed value must agree.
                exp_one = expected_results[$];
                if (exp_one != rows[i].res) begin
                    errors++;
                    $display("Directed row %0d disagrees with the predictor", i);
                end
            end
        end
        wait_drained();

        // Random phases, one hold setting and one idling pattern each.
        for (int ph = 0; ph < 4; ph++) begin
            write_hold(hold_settings[ph]);
            send_idle_pct = phase_pct[ph][0];
            recv_stall_pct = phase_pct[ph][1];
            base = (ph == 1) ? 64'hFFFF_FFFF_FFFF_FE00 : 64'd0;
            for (int i = 0; i < 112; i++) begin
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                        base = base + 64'($urandom_range(40));
                        req = make_req(OP_PUSH, 2'($urandom_range(3)), base, $urandom, '0);
                    end
                    12: req = make_req(OP_PUSH, 2'($urandom_range(3)), rand64(),
                                       $urandom, '0);
                    13: req = make_req(OP_PUSH, 2'($urandom_range(3)),
                                       base - 64'($urandom_range(100)), $urandom, '0);
                    14: req = make_req(OP_DRAIN_ALL, 2'($urandom_range(3)), rand64(),
                                       $urandom, rand64());
                    15: req = make_req(OP_UNKNOWN, 2'($urandom_range(3)), rand64(),
                                       $urandom, rand64());
                    16: req = make_req(OP_DRAIN_OLD, 2'd0, '0, '0, rand64());
                    default: req = make_req(OP_DRAIN_OLD, 2'($urandom_range(3)), rand64(),
                                            $urandom,
                                            base + 64'd1000 - 64'($urandom_range(300)));
                endcase
                send_request(req);
            end
            send_request(make_req(OP_DRAIN_ALL, 2'd0, '0, '0, '0));
            wait_drained();
        end

        $display("Sent %0d requests, checked %0d results of which %0d were emitted events.",
                 sent, received, emitted);
        $display("Hold delay covered zero, one, 1000 and all ones, under four idling patterns.");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* timestamp_ordered_multi_source_merge_core.f */
design/tsmrg_pkg.sv
design/tsmrg_ctrl.sv
design/tsmrg_dp.sv
design/timestamp_ordered_multi_source_merge_core.sv
dv/tb_timestamp_ordered_multi_source_merge_core.sv
